// ===== rtl/page_framebuffer_glyph_engine_defines.svh =====
// ----------------------------------------------------------------------------
// Glyph engine assertion macros
// Shared macros that wrap concurrent assertions for the glyph engine checks.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_GLYPH_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_GLYPH_ENGINE_DEFINES_SVH

// Assertion that is checked only while the block is out of reset.
`define PFGE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define PFGE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pfge_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph engine package
// Shared types, transfer codes and the 5x7 font table.
// ----------------------------------------------------------------------------
`default_nettype none

package pfge_pkg;

    localparam int STORE_AW = 11;

    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;

    localparam logic [7:0] CTRL_CMD    = 8'h00;
    localparam logic [7:0] CTRL_DATA   = 8'h40;
    localparam logic [7:0] CMD_PAGE    = 8'hB0;
    localparam logic [7:0] CMD_COL_LO  = 8'h00;
    localparam logic [7:0] CMD_COL_HI  = 8'h10;
    localparam logic [7:0] NIBBLE_MASK = 8'h0F;

    localparam logic [7:0] FIRST_CODE    = 8'h20;
    localparam logic [7:0] LAST_CODE     = 8'h7E;
    localparam logic [7:0] FALLBACK_CODE = 8'h3F;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] waddr;
        logic [7:0]          wdata;
        logic [STORE_AW-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [7:0]  ctrl_byte;
        logic [63:0] payload;
        logic [3:0]  byte_count;
        logic        end_of_transfer;
        logic        last;
    } t_result;

    // Column c of a glyph sits in bits [8c+6:8c]; bit 0 is the top row.
    localparam logic [39:0] FONT [0:94] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
        40'h0041221C00, 40'h001C224100, 40'h14083E0814, 40'h08083E0808,
        40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
        40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
        40'h107F121418, 40'h3945454527,
        40'h3049494A3C, 40'h0305097101, 40'h3649494936, 40'h1E29494906,
        40'h0000363600, 40'h0000365600, 40'h0041221408, 40'h1414141414,
        40'h0814224100, 40'h0609510102, 40'h3E41794932, 40'h7E1111117E,
        40'h364949497F, 40'h224141413E, 40'h1C2241417F, 40'h414949497F,
        40'h010909097F, 40'h7A4949413E, 40'h7F0808087F, 40'h00417F4100,
        40'h013F414020, 40'h412214087F, 40'h404040407F, 40'h7F020C027F,
        40'h7F1008047F, 40'h3E4141413E, 40'h060909097F, 40'h5E2151413E,
        40'h462919097F, 40'h3149494946, 40'h01017F0101, 40'h3F4040403F,
        40'h1F2040201F, 40'h7F2018207F, 40'h6314081463, 40'h0304780403,
        40'h4345495161, 40'h0041417F00, 40'h2010080402, 40'h007F414100,
        40'h0402010204, 40'h4040404040, 40'h0004020100, 40'h7854545420,
        40'h384444487F, 40'h2044444438, 40'h7F48444438, 40'h1854545438,
        40'h0201097E08, 40'h3E5252520C, 40'h780404087F, 40'h00407D4400,
        40'h003D444020, 40'h004428107F, 40'h00407F4100, 40'h780418047C,
        40'h780404087C, 40'h3844444438, 40'h081414147C, 40'h7C18141408,
        40'h080404087C, 40'h2054545448, 40'h2040443F04, 40'h7C2040403C,
        40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h3C5050500C,
        40'h444C546444, 40'h0041360800, 40'h00007F0000, 40'h0008364100,
        40'h0810080408
    };

endpackage

`default_nettype wire

// ===== rtl/pfge_store.sv =====
// ----------------------------------------------------------------------------
// Glyph engine frame store
// Page-organized byte memory, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pfge_store #(
    parameter int DEPTH = 1024
) (
    input  wire                     i_clk,
    input  wire pfge_pkg::t_mem_req i_req,
    output logic [7:0]              o_rdata
);

    localparam int AW = $clog2(DEPTH);

    logic [7:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr[AW-1:0]] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.raddr[AW-1:0]];
    end

endmodule

`default_nettype wire

// ===== rtl/pfge_outbuf.sv =====
// ----------------------------------------------------------------------------
// Glyph engine output register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module pfge_outbuf (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_push,
    input  wire pfge_pkg::t_result i_res,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire                    i_take,
    output pfge_pkg::t_result      o_res
);

    logic r_valid;
    logic n_valid;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;

    always_comb begin
        n_valid = r_valid;
        if (i_take) begin
            n_valid = 1'b0;
        end
        if (i_push && o_ready) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_ready) begin
            o_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pfge_ctrl.sv =====
// ----------------------------------------------------------------------------
// Glyph engine sequencer
// Clear sweep, pixel read-modify-write walk for glyphs, and page flush.
// ----------------------------------------------------------------------------
`default_nettype none

module pfge_ctrl #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64,
    parameter int CHUNK_BYTES  = 16,
    parameter int MAX_SCALE    = 8
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [1:0]         i_action,
    input  wire  signed [8:0]  i_x_pos,
    input  wire  signed [8:0]  i_y_pos,
    input  wire  [7:0]         i_char_code,
    input  wire  [3:0]         i_scale,
    input  wire  [2:0]         i_page_index,
    input  wire  [7:0]         i_col_offset,
    output pfge_pkg::t_mem_req o_mem,
    input  wire  [7:0]         i_rdata,
    output logic               o_push,
    output pfge_pkg::t_result  o_res,
    input  wire                i_out_ready
);

    localparam int PAGES       = (PANEL_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = PANEL_WIDTH * PAGES;
    localparam int AW          = $clog2(STORE_BYTES);
    localparam int BW          = $clog2(PANEL_WIDTH);
    localparam int CW          = $clog2(CHUNK_BYTES);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DRAW = 3'd2;
    localparam logic [2:0] S_DEND = 3'd3;
    localparam logic [2:0] S_CMD  = 3'd4;
    localparam logic [2:0] S_FRD  = 3'd5;
    localparam logic [2:0] S_FACC = 3'd6;
    localparam logic [2:0] S_FOUT = 3'd7;

    logic [2:0]         r_state, n_state;
    logic [AW-1:0]      r_addr, n_addr;
    logic [39:0]        r_glyph, n_glyph;
    logic [2:0]         r_scm1, n_scm1;
    logic [2:0]         r_col, n_col, r_dx, n_dx, r_row, n_row, r_dy, n_dy;
    logic signed [10:0] r_px, n_px, r_py, n_py, r_y0, n_y0;
    logic               r_s1_valid, n_s1_valid;
    logic [AW-1:0]      r_s1_addr, n_s1_addr;
    logic [7:0]         r_s1_mask, n_s1_mask;
    logic               r_wb_valid;
    logic [AW-1:0]      r_wb_addr;
    logic [7:0]         r_wb_data;
    logic [2:0]         r_page, n_page;
    logic [1:0]         r_cmd, n_cmd;
    logic [BW-1:0]      r_bidx, n_bidx;
    logic [CW-1:0]      r_cpos, n_cpos;
    logic [2:0]         r_rpos, n_rpos;
    logic [63:0]        r_acc, n_acc;
    logic               r_eot, n_eot, r_last, n_last;

    logic [7:0]         rmw_data;
    logic               pix_on, pix_in;
    logic [AW-1:0]      pix_addr;
    logic [6:0]         glyph_idx;
    logic [3:0]         sc_sat;
    logic               at_eot, at_last;

    assign o_ready = (r_state == S_IDLE);

    // A pixel write that lands on the byte written in the previous cycle sees
    // stale read data, so the last written byte is forwarded.
    assign rmw_data = ((r_wb_valid && (r_wb_addr == r_s1_addr)) ? r_wb_data : i_rdata)
                      | r_s1_mask;

    assign pix_on   = r_glyph[{r_col, r_row}];
    assign pix_in   = !r_px[10] && (r_px < $signed(11'(PANEL_WIDTH)))
                      && !r_py[10] && (r_py < $signed(11'(PANEL_HEIGHT)));
    assign pix_addr = AW'(r_py[10:3]) * AW'(PANEL_WIDTH) + AW'(r_px);

    assign glyph_idx = ((i_char_code < pfge_pkg::FIRST_CODE)
                        || (i_char_code > pfge_pkg::LAST_CODE))
                       ? 7'(pfge_pkg::FALLBACK_CODE - pfge_pkg::FIRST_CODE)
                       : 7'(i_char_code - pfge_pkg::FIRST_CODE);
    assign sc_sat    = (i_scale == 4'd0) ? 4'd1
                     : (i_scale > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : i_scale;

    assign at_last = (r_bidx == BW'(PANEL_WIDTH - 1));
    assign at_eot  = at_last || (r_cpos == CW'(CHUNK_BYTES - 1));

    always_comb begin
        o_mem       = '0;
        o_mem.raddr = pfge_pkg::STORE_AW'(pix_addr);
        if (r_state == S_CLR) begin
            o_mem.we    = 1'b1;
            o_mem.waddr = pfge_pkg::STORE_AW'(r_addr);
        end else if (r_s1_valid) begin
            o_mem.we    = 1'b1;
            o_mem.waddr = pfge_pkg::STORE_AW'(r_s1_addr);
            o_mem.wdata = rmw_data;
        end
        if (r_state == S_FRD) begin
            o_mem.raddr = pfge_pkg::STORE_AW'(AW'(r_page) * AW'(PANEL_WIDTH) + AW'(r_bidx));
        end
    end

    always_comb begin
        o_push = 1'b0;
        o_res  = '0;
        if (r_state == S_CMD) begin
            o_push           = 1'b1;
            o_res.ctrl_byte  = pfge_pkg::CTRL_CMD;
            o_res.byte_count = 4'd1;
            o_res.end_of_transfer = 1'b1;
            case (r_cmd)
                2'd0:    o_res.payload = 64'(pfge_pkg::CMD_PAGE | 8'(r_page));
                2'd1:    o_res.payload = 64'(pfge_pkg::CMD_COL_LO
                                             | (i_col_offset & pfge_pkg::NIBBLE_MASK));
                default: o_res.payload = 64'(pfge_pkg::CMD_COL_HI
                                             | (i_col_offset >> 4));
            endcase
        end else if (r_state == S_FOUT) begin
            o_push                = 1'b1;
            o_res.ctrl_byte       = pfge_pkg::CTRL_DATA;
            o_res.payload         = r_acc;
            o_res.byte_count      = 4'(r_rpos) + 4'd1;
            o_res.end_of_transfer = r_eot;
            o_res.last            = r_last;
        end
    end

    always_comb begin
        n_state = r_state;  n_addr = r_addr;   n_glyph = r_glyph; n_scm1 = r_scm1;
        n_col = r_col;      n_dx = r_dx;       n_row = r_row;     n_dy = r_dy;
        n_px = r_px;        n_py = r_py;       n_y0 = r_y0;
        n_s1_valid = 1'b0;  n_s1_addr = pix_addr;
        n_s1_mask = 8'(1 << r_py[2:0]);
        n_page = r_page;    n_cmd = r_cmd;     n_bidx = r_bidx;   n_cpos = r_cpos;
        n_rpos = r_rpos;    n_acc = r_acc;     n_eot = r_eot;     n_last = r_last;
        unique case (r_state)
            S_CLR: begin
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(STORE_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    case (i_action)
                        pfge_pkg::ACT_CLEAR: begin
                            n_addr  = '0;
                            n_state = S_CLR;
                        end
                        pfge_pkg::ACT_DRAW: begin
                            n_glyph = pfge_pkg::FONT[glyph_idx];
                            n_scm1  = 3'(sc_sat - 4'd1);
                            n_col = '0; n_dx = '0; n_row = '0; n_dy = '0;
                            n_px  = 11'(i_x_pos);
                            n_py  = 11'(i_y_pos);
                            n_y0  = 11'(i_y_pos);
                            n_state = S_DRAW;
                        end
                        pfge_pkg::ACT_FLUSH: begin
                            if ({1'b0, i_page_index} < 4'(PAGES)) begin
                                n_page  = i_page_index;
                                n_cmd   = '0;
                                n_state = S_CMD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_DRAW: begin
                n_s1_valid = pix_on && pix_in;
                if (r_dy != r_scm1) begin
                    n_dy = r_dy + 3'd1;
                    n_py = r_py + 11'sd1;
                end else begin
                    n_dy = '0;
                    if (r_row != 3'd6) begin
                        n_row = r_row + 3'd1;
                        n_py  = r_py + 11'sd1;
                    end else begin
                        n_row = '0;
                        n_py  = r_y0;
                        n_px  = r_px + 11'sd1;
                        if (r_dx != r_scm1) begin
                            n_dx = r_dx + 3'd1;
                        end else begin
                            n_dx = '0;
                            if (r_col != 3'd4) begin
                                n_col = r_col + 3'd1;
                            end else begin
                                n_state = S_DEND;
                            end
                        end
                    end
                end
            end
            S_DEND: begin
                n_state = S_IDLE;
            end
            S_CMD: begin
                if (i_out_ready) begin
                    n_cmd = r_cmd + 2'd1;
                    if (r_cmd == 2'd2) begin
                        n_bidx = '0; n_cpos = '0; n_rpos = '0; n_acc = '0;
                        n_state = S_FRD;
                    end
                end
            end
            S_FRD: begin
                n_state = S_FACC;
            end
            S_FACC: begin
                n_acc[8*r_rpos +: 8] = i_rdata;
                n_eot  = at_eot;
                n_last = at_last;
                if (at_eot || (r_rpos == 3'd7)) begin
                    n_state = S_FOUT;
                end else begin
                    n_bidx  = r_bidx + BW'(1);
                    n_cpos  = r_cpos + CW'(1);
                    n_rpos  = r_rpos + 3'd1;
                    n_state = S_FRD;
                end
            end
            S_FOUT: begin
                if (i_out_ready) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_bidx  = r_bidx + BW'(1);
                        n_cpos  = r_eot ? '0 : r_cpos + CW'(1);
                        n_rpos  = '0;
                        n_acc   = '0;
                        n_state = S_FRD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_addr     <= '0;
            r_s1_valid <= 1'b0;
            r_wb_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_s1_valid <= n_s1_valid;
            r_wb_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_glyph <= n_glyph; r_scm1 <= n_scm1;
        r_col <= n_col; r_dx <= n_dx; r_row <= n_row; r_dy <= n_dy;
        r_px <= n_px; r_py <= n_py; r_y0 <= n_y0;
        r_s1_addr <= n_s1_addr; r_s1_mask <= n_s1_mask;
        r_wb_addr <= r_s1_addr; r_wb_data <= rmw_data;
        r_page <= n_page; r_cmd <= n_cmd; r_bidx <= n_bidx; r_cpos <= n_cpos;
        r_rpos <= n_rpos; r_acc <= n_acc; r_eot <= n_eot; r_last <= n_last;
    end

endmodule

`default_nettype wire

// ===== rtl/page_framebuffer_glyph_engine.sv =====
// ----------------------------------------------------------------------------
// Page framebuffer glyph engine
// Monochrome page-organized frame store with a 5x7 glyph renderer and a
// page flush that turns the store into command and display data transfers.
// ----------------------------------------------------------------------------
//
// Channel     Direction  Handshake                 Contents
// s_axis      in         tvalid/tready             action, glyph position, code, scale, page
// m_axis      out        tvalid/tready/tlast       transfer results
// APB         in/out     psel/penable/pready       col_offset register
//
// After reset the store is swept to zero, one byte a cycle, over all
// PANEL_WIDTH * pages bytes (1024 by default); no transaction is taken then.
// A clear action repeats the same sweep. A glyph draw walks 35 * scale^2
// pixels, one per cycle, with a read-modify-write of the frame memory for
// each lit pixel inside the panel. A flush sends three command transfers,
// then reads each page byte from memory and packs it into results; the output
// register stalls the flush whenever the downstream side holds tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_glyph_engine #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64,
    parameter int CHUNK_BYTES  = 16,
    parameter int MAX_SCALE    = 8
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Input items.
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: x_pos[8:0], y_pos[17:9], char_code[25:18], scale[29:26],
    // page_index[32:30], zero fill [39:33]
    input  wire  [39:0] s_axis_tdata,
    // tuser: action[1:0]
    input  wire  [1:0]  s_axis_tuser,
    // Results.
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: payload[63:0], byte_count[67:64], end_of_transfer[68], zero [71:69]
    output logic [71:0] m_axis_tdata,
    // tuser: ctrl_byte[7:0]
    output logic [7:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration port.
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PAGES = (PANEL_HEIGHT + 7) / 8;

    logic              r_col_offset;
    logic [7:0]        r_col_off;
    pfge_pkg::t_mem_req mem_req;
    logic [7:0]        mem_rdata;
    logic              res_push;
    logic              res_ready;
    pfge_pkg::t_result res_in;
    pfge_pkg::t_result res_out;

    // The only register lives at byte address 0; the word address decides.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, r_col_off} : 32'd0;
    assign r_col_offset = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_off <= 8'd0;
        end else if (r_col_offset) begin
            r_col_off <= pwdata[7:0];
        end
    end

    pfge_ctrl #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .CHUNK_BYTES  (CHUNK_BYTES),
        .MAX_SCALE    (MAX_SCALE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_action     (s_axis_tuser),
        .i_x_pos      (s_axis_tdata[8:0]),
        .i_y_pos      (s_axis_tdata[17:9]),
        .i_char_code  (s_axis_tdata[25:18]),
        .i_scale      (s_axis_tdata[29:26]),
        .i_page_index (s_axis_tdata[32:30]),
        .i_col_offset (r_col_off),
        .o_mem        (mem_req),
        .i_rdata      (mem_rdata),
        .o_push       (res_push),
        .o_res        (res_in),
        .i_out_ready  (res_ready)
    );

    pfge_store #(
        .DEPTH (PANEL_WIDTH * PAGES)
    ) u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    pfge_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_ready (res_ready),
        .o_valid (m_axis_tvalid),
        .i_take  (m_axis_tready),
        .o_res   (res_out)
    );

    assign m_axis_tdata = {3'd0, res_out.end_of_transfer, res_out.byte_count,
                           res_out.payload};
    assign m_axis_tuser = res_out.ctrl_byte;
    assign m_axis_tlast = res_out.last;

endmodule

`default_nettype wire

// ===== rtl/pfge_checker.sv =====
// ----------------------------------------------------------------------------
// Glyph engine port checker
// Watches the top-level ports for transfer and handshake consistency.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_framebuffer_glyph_engine_defines.svh"

module pfge_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [39:0] s_axis_tdata,
    input wire [1:0]  s_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [71:0] m_axis_tdata,
    input wire [7:0]  m_axis_tuser,
    input wire        m_axis_tlast,
    input wire        psel,
    input wire        penable,
    input wire        pwrite,
    input wire [2:0]  paddr,
    input wire [31:0] pwdata,
    input wire [31:0] prdata,
    input wire        pready
);

    // A stalled result stays valid with its tdata unchanged.
    property p_out_hold;
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata);
    endproperty

    // The end of a flush always closes a display data transfer.
    property p_last_closes;
        m_axis_tvalid && m_axis_tlast
            |-> m_axis_tdata[68] && (m_axis_tuser == pfge_pkg::CTRL_DATA);
    endproperty

    // Command transfers carry exactly one byte.
    property p_cmd_single;
        m_axis_tvalid && (m_axis_tuser == pfge_pkg::CTRL_CMD)
            |-> (m_axis_tdata[67:64] == 4'd1) && m_axis_tdata[68];
    endproperty

    // Every result carries one to eight bytes.
    property p_count_range;
        m_axis_tvalid |-> (m_axis_tdata[67:64] != 4'd0)
            && (m_axis_tdata[67] == 1'b0 || m_axis_tdata[66:64] == 3'd0);
    endproperty

    `PFGE_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "result changed while stalled")
    `PFGE_ASSERT(a_last_closes, i_clk, i_rst_n, p_last_closes, "flush end not a data close")
    `PFGE_ASSERT(a_cmd_single, i_clk, i_rst_n, p_cmd_single, "command transfer not one byte")
    `PFGE_ASSERT(a_count_range, i_clk, i_rst_n, p_count_range, "byte count out of range")

endmodule

bind page_framebuffer_glyph_engine pfge_checker u_pfge_checker (.*);

`default_nettype wire
